[sv/lifsoma_pkg.sv]
// Package for the leaky integrate-and-fire soma update block.
// Holds field widths, register indexes, event and reset-mode codes.
// No dependencies.
`default_nettype none

package lifsoma_pkg;

	// Default width of the stored membrane potential
	localparam int POT_WIDTH_DEF = 24;

	// Field widths
	localparam int SYN_W   = 24;
	localparam int NOISE_W = 4;
	localparam int LEAK_W  = 16;
	localparam int BIAS_W  = 16;
	localparam int THR_W   = 24;
	localparam int EVENT_W = 2;
	localparam int OUTP_W  = 24;
	localparam int RKIND_W = 2;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Stream data widths, padded to whole bytes
	localparam int S_TDATA_W = ((SYN_W + NOISE_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((OUTP_W + 7) / 8) * 8;
	localparam int M_TUSER_W = EVENT_W;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LEAK       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRE_THR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REV_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIRE_RESET = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REV_RESET  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_KIND = 3'd6;

	// Event codes
	localparam logic [EVENT_W-1:0] EV_IDLE = 2'd0;
	localparam logic [EVENT_W-1:0] EV_FIRE = 2'd1;
	localparam logic [EVENT_W-1:0] EV_REV  = 2'd2;

	// Reset modes; the fourth code reports the event and keeps the potential
	localparam logic [RKIND_W-1:0] RK_HARD   = 2'd0;
	localparam logic [RKIND_W-1:0] RK_SOFT   = 2'd1;
	localparam logic [RKIND_W-1:0] RK_SAT    = 2'd2;
	localparam logic [RKIND_W-1:0] RK_UNUSED = 2'd3;

	// Register reset values
	localparam logic [THR_W-1:0] FIRE_THR_RST  = 24'h000001;
	localparam logic [THR_W-1:0] REV_LIMIT_RST = 24'h800000;

endpackage

`default_nettype wire

[sv/lif_neuron_soma_update_top.sv]
// Top level of the leaky integrate-and-fire soma update: one membrane update
// per request, input register, update logic, result register, config bank.
// Depends on lifsoma_pkg.
//
// Usage:
//   s_* channel: one request per neuron time step. s_tdata carries the summed
//   synaptic input and the noise offset (0..9 normally) used only for the
//   threshold compares.
//   m_* channel: one result per request, in order. m_tuser carries the event
//   (idle, fired, reverse) and m_tdata the potential after the update.
//   cfg_* channel: register writes (index, data), always ready. Write only
//   while the block is idle; unknown indexes are dropped.
// Timing: a request taken at a clock edge is held in the input register; the
//   update runs combinationally from there into the result register, which
//   loads as soon as its slot is free. One request per clock is sustained while
//   m_tready stays high; the limit is the combinational leak, accumulate,
//   compare and reset path on the potential register.
// Stall: when the receiver holds m_tready low, the result register holds, the
//   input register holds one more request, and s_tready drops after that.
// Reset: arst_n clears both valid flags, the potential to zero and the
//   registers to their defaults (threshold 1, reverse limit most negative).
`default_nettype none

module lif_neuron_soma_update_top #(
	parameter int POT_WIDTH = lifsoma_pkg::POT_WIDTH_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// request stream
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// [23:0] syn_input, [27:24] noise_offset, [31:28] zero
	input  wire logic [lifsoma_pkg::S_TDATA_W-1:0]      s_tdata,
	// result stream
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// [23:0] new_potential
	output logic [lifsoma_pkg::M_TDATA_W-1:0]           m_tdata,
	// [1:0] event_kind
	output logic [lifsoma_pkg::M_TUSER_W-1:0]           m_tuser,
	// register writes
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [lifsoma_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [lifsoma_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// Arithmetic width: holds the widest operand plus two guard bits so sums
	// of potential, input and bias never wrap before saturation.
	localparam int BASE_W = (POT_WIDTH > lifsoma_pkg::SYN_W) ? POT_WIDTH : lifsoma_pkg::SYN_W;
	localparam int EW     = BASE_W + 2;

	localparam logic signed [EW-1:0] POT_MAX = EW'((64'sd1 <<< (POT_WIDTH - 1)) - 64'sd1);
	localparam logic signed [EW-1:0] POT_MIN = -POT_MAX - EW'(1);

	// Clamp a wide value into the potential range
	function automatic logic signed [POT_WIDTH-1:0] sat_pot(input logic signed [EW-1:0] x);
		logic signed [EW-1:0] y;
		y = x;
		if (x > POT_MAX) begin
			y = POT_MAX;
		end else if (x < POT_MIN) begin
			y = POT_MIN;
		end
		return y[POT_WIDTH-1:0];
	endfunction

	// ---------------- configuration registers ----------------
	logic [lifsoma_pkg::LEAK_W-1:0]  leak_q;
	logic [lifsoma_pkg::BIAS_W-1:0]  bias_q;
	logic [lifsoma_pkg::THR_W-1:0]   fire_thr_q;
	logic [lifsoma_pkg::THR_W-1:0]   rev_limit_q;
	logic [lifsoma_pkg::THR_W-1:0]   fire_rst_q;
	logic [lifsoma_pkg::THR_W-1:0]   rev_rst_q;
	logic [lifsoma_pkg::RKIND_W-1:0] rkind_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leak_q      <= '0;
			bias_q      <= '0;
			fire_thr_q  <= lifsoma_pkg::FIRE_THR_RST;
			rev_limit_q <= lifsoma_pkg::REV_LIMIT_RST;
			fire_rst_q  <= '0;
			rev_rst_q   <= '0;
			rkind_q     <= lifsoma_pkg::RK_HARD;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lifsoma_pkg::REG_LEAK:       leak_q      <= cfg_data[lifsoma_pkg::LEAK_W-1:0];
				lifsoma_pkg::REG_BIAS:       bias_q      <= cfg_data[lifsoma_pkg::BIAS_W-1:0];
				lifsoma_pkg::REG_FIRE_THR:   fire_thr_q  <= cfg_data[lifsoma_pkg::THR_W-1:0];
				lifsoma_pkg::REG_REV_LIMIT:  rev_limit_q <= cfg_data[lifsoma_pkg::THR_W-1:0];
				lifsoma_pkg::REG_FIRE_RESET: fire_rst_q  <= cfg_data[lifsoma_pkg::THR_W-1:0];
				lifsoma_pkg::REG_REV_RESET:  rev_rst_q   <= cfg_data[lifsoma_pkg::THR_W-1:0];
				lifsoma_pkg::REG_RESET_KIND: rkind_q     <= cfg_data[lifsoma_pkg::RKIND_W-1:0];
				default: begin
					// unknown index: drop the write
				end
			endcase
		end
	end

	// ---------------- input register ----------------
	logic                                valid_s1;
	logic [lifsoma_pkg::SYN_W-1:0]       syn_s1;
	logic [lifsoma_pkg::NOISE_W-1:0]     noise_s1;
	logic                                advance;

	// Move the held request into the result register when that slot is free
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			syn_s1   <= s_tdata[lifsoma_pkg::SYN_W-1:0];
			noise_s1 <= s_tdata[lifsoma_pkg::SYN_W +: lifsoma_pkg::NOISE_W];
		end
	end

	// ---------------- membrane update ----------------
	logic signed [POT_WIDTH-1:0] pot_q;

	logic signed [EW-1:0] pot_x, leak_x, bias_x, syn_x, thr_x, rev_x;
	logic signed [EW-1:0] fire_rst_x, rev_rst_x, noise_x;
	logic signed [POT_WIDTH-1:0] leaked, accum, pot_next;
	logic signed [EW-1:0] accum_x, noisy;
	logic [lifsoma_pkg::EVENT_W-1:0] event_next;

	always_comb begin
		pot_x      = $signed({{(EW-POT_WIDTH){pot_q[POT_WIDTH-1]}}, pot_q});
		leak_x     = $signed({{(EW-lifsoma_pkg::LEAK_W){leak_q[lifsoma_pkg::LEAK_W-1]}}, leak_q});
		bias_x     = $signed({{(EW-lifsoma_pkg::BIAS_W){bias_q[lifsoma_pkg::BIAS_W-1]}}, bias_q});
		syn_x      = $signed({{(EW-lifsoma_pkg::SYN_W){syn_s1[lifsoma_pkg::SYN_W-1]}}, syn_s1});
		thr_x      = $signed({{(EW-lifsoma_pkg::THR_W){fire_thr_q[lifsoma_pkg::THR_W-1]}},
			fire_thr_q});
		rev_x      = $signed({{(EW-lifsoma_pkg::THR_W){rev_limit_q[lifsoma_pkg::THR_W-1]}},
			rev_limit_q});
		fire_rst_x = $signed({{(EW-lifsoma_pkg::THR_W){fire_rst_q[lifsoma_pkg::THR_W-1]}},
			fire_rst_q});
		rev_rst_x  = $signed({{(EW-lifsoma_pkg::THR_W){rev_rst_q[lifsoma_pkg::THR_W-1]}},
			rev_rst_q});
		noise_x    = $signed({{(EW-lifsoma_pkg::NOISE_W){1'b0}}, noise_s1});

		// leak toward zero (away from zero when leak_q is negative)
		priority if (pot_q > 0) begin
			leaked = sat_pot(pot_x - leak_x);
		end else if (pot_q < 0) begin
			leaked = sat_pot(pot_x + leak_x);
		end else begin
			leaked = pot_q;
		end

		// integrate input and bias in one step
		accum   = sat_pot($signed({{(EW-POT_WIDTH){leaked[POT_WIDTH-1]}}, leaked})
			+ syn_x + bias_x);
		accum_x = $signed({{(EW-POT_WIDTH){accum[POT_WIDTH-1]}}, accum});
		noisy   = accum_x + noise_x;

		// fire has priority over reverse
		pot_next   = accum;
		event_next = lifsoma_pkg::EV_IDLE;
		priority if (noisy >= thr_x) begin
			event_next = lifsoma_pkg::EV_FIRE;
			unique case (rkind_q)
				lifsoma_pkg::RK_HARD:   pot_next = sat_pot(fire_rst_x);
				lifsoma_pkg::RK_SOFT:   pot_next = sat_pot(accum_x - thr_x);
				lifsoma_pkg::RK_SAT:    pot_next = sat_pot(thr_x);
				lifsoma_pkg::RK_UNUSED: pot_next = accum;
				default:                pot_next = accum;
			endcase
		end else if (noisy <= rev_x) begin
			event_next = lifsoma_pkg::EV_REV;
			unique case (rkind_q)
				lifsoma_pkg::RK_HARD:   pot_next = sat_pot(rev_rst_x);
				lifsoma_pkg::RK_SOFT:   pot_next = sat_pot(accum_x + rev_x);
				lifsoma_pkg::RK_SAT:    pot_next = sat_pot(rev_x);
				lifsoma_pkg::RK_UNUSED: pot_next = accum;
				default:                pot_next = accum;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pot_q <= '0;
		end else if (advance) begin
			pot_q <= pot_next;
		end
	end

	// ---------------- result register ----------------
	logic signed [EW-1:0]               pot_next_x;
	logic [lifsoma_pkg::OUTP_W-1:0]     outp_q;
	logic [lifsoma_pkg::EVENT_W-1:0]    event_q;
	logic                               out_valid_q;

	assign pot_next_x = $signed({{(EW-POT_WIDTH){pot_next[POT_WIDTH-1]}}, pot_next});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			outp_q  <= pot_next_x[lifsoma_pkg::OUTP_W-1:0];
			event_q <= event_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(lifsoma_pkg::M_TDATA_W-lifsoma_pkg::OUTP_W){1'b0}}, outp_q};
	assign m_tuser  = event_q;

	// ---------------- assertions ----------------
	logic signed [EW-1:0] pot_q_x;
	assign pot_q_x = $signed({{(EW-POT_WIDTH){pot_q[POT_WIDTH-1]}}, pot_q});

	a_pot_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(pot_q))
		else $error("potential changed without an update");

	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("update did not produce a result");

	a_out_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (outp_q == pot_q_x[lifsoma_pkg::OUTP_W-1:0]))
		else $error("offered potential differs from stored potential");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_tvalid && !m_tready))
		else $error("request side stalled without a full pipeline");

endmodule

`default_nettype wire

[tb/lifsoma_checker.sv]
// Checker for the leaky integrate-and-fire soma update block.
// Watches request, result and register-write channels, predicts each update
// and compares results in order. Depends on lifsoma_pkg.
`timescale 1ns / 1ps

module lifsoma_checker
	import lifsoma_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [M_TDATA_W-1:0]  m_tdata,
	input  wire logic [M_TUSER_W-1:0]  m_tuser,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         errors,
	output int                         pending
);

	localparam int POT_W = POT_WIDTH_DEF;
	localparam longint POT_MAX = (64'sd1 <<< (POT_W - 1)) - 1;
	localparam longint POT_MIN = -POT_MAX - 1;

	typedef struct packed {
		logic [EVENT_W-1:0] ev;
		logic [OUTP_W-1:0]  pot;
	} soma_result_t;

	// shadow register bank and membrane state
	logic [LEAK_W-1:0]  leak_amt;
	logic [BIAS_W-1:0]  bias_amt;
	logic [THR_W-1:0]   fire_thr;
	logic [THR_W-1:0]   rev_limit;
	logic [THR_W-1:0]   fire_rst;
	logic [THR_W-1:0]   rev_rst;
	logic [RKIND_W-1:0] rkind;
	longint             membrane;

	soma_result_t expected_updates[$];
	soma_result_t want;

	function automatic longint clamp_pot(input longint x);
		if (x > POT_MAX)
			return POT_MAX;
		if (x < POT_MIN)
			return POT_MIN;
		return x;
	endfunction

	function automatic soma_result_t soma_update(input logic [SYN_W-1:0] syn,
			input logic [NOISE_W-1:0] noise);
		longint leak, bias, thr, rev, syn_v, noise_v, p, noisy;
		soma_result_t r;
		leak    = $signed(leak_amt);
		bias    = $signed(bias_amt);
		thr     = $signed(fire_thr);
		rev     = $signed(rev_limit);
		syn_v   = $signed(syn);
		noise_v = noise;
		p       = membrane;
		r.ev    = EV_IDLE;

		// leak toward zero (away for a negative leak), then integrate input and bias in one step
		if (p > 0)
			p = clamp_pot(p - leak);
		else if (p < 0)
			p = clamp_pot(p + leak);
		p = clamp_pot(p + syn_v + bias);
		noisy = p + noise_v;

		if (noisy >= thr) begin
			r.ev = EV_FIRE;
			case (rkind)
				RK_HARD: p = clamp_pot($signed(fire_rst));
				RK_SOFT: p = clamp_pot(p - thr);
				RK_SAT:  p = clamp_pot(thr);
				default: ;
			endcase
		end else if (noisy <= rev) begin
			r.ev = EV_REV;
			case (rkind)
				RK_HARD: p = clamp_pot($signed(rev_rst));
				RK_SOFT: p = clamp_pot(p + rev);
				RK_SAT:  p = clamp_pot(rev);
				default: ;
			endcase
		end
		membrane = p;
		r.pot    = p[OUTP_W-1:0];
		return r;
	endfunction

	task automatic flag(input string msg);
		$display("%0t lifsoma_checker: %s", $time, msg);
		errors = errors + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leak_amt  = '0;
			bias_amt  = '0;
			fire_thr  = FIRE_THR_RST;
			rev_limit = REV_LIMIT_RST;
			fire_rst  = '0;
			rev_rst   = '0;
			rkind     = RK_HARD;
			membrane  = 0;
			errors    = 0;
			expected_updates.delete();
			pending   = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_updates.size() == 0) begin
					flag($sformatf("result with no request waiting: ev %0d pot %h",
						m_tuser, m_tdata));
				end else begin
					want = expected_updates.pop_front();
					if (m_tuser !== want.ev)
						flag($sformatf("event_kind got %0d want %0d", m_tuser, want.ev));
					if (m_tdata[OUTP_W-1:0] !== want.pot)
						flag($sformatf("new_potential got %h want %h",
							m_tdata[OUTP_W-1:0], want.pot));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LEAK:       leak_amt  = cfg_data[LEAK_W-1:0];
					REG_BIAS:       bias_amt  = cfg_data[BIAS_W-1:0];
					REG_FIRE_THR:   fire_thr  = cfg_data[THR_W-1:0];
					REG_REV_LIMIT:  rev_limit = cfg_data[THR_W-1:0];
					REG_FIRE_RESET: fire_rst  = cfg_data[THR_W-1:0];
					REG_REV_RESET:  rev_rst   = cfg_data[THR_W-1:0];
					REG_RESET_KIND: rkind     = cfg_data[RKIND_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_updates.push_back(soma_update(s_tdata[SYN_W-1:0],
					s_tdata[SYN_W +: NOISE_W]));
			pending = expected_updates.size();
		end
	end

endmodule

[tb/tb.sv]
// Top of the soma update testbench: clock, reset, request and register-write
// stimulus, result back-pressure and the final verdict.
// Depends on lifsoma_pkg, lifsoma_checker and lif_neuron_soma_update_top.
`timescale 1ns / 1ps

module tb;
	import lifsoma_pkg::*;

	// index past the register bank; the block must drop writes to it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	localparam logic [SYN_W-1:0] SYN_MAX = 24'h7FFFFF;
	localparam logic [SYN_W-1:0] SYN_MIN = 24'h800000;
	localparam logic [LEAK_W-1:0] L16_MAX = 16'h7FFF;
	localparam logic [LEAK_W-1:0] L16_MIN = 16'h8000;

	localparam int PHASES     = 12;
	localparam int PHASE_REQS = 75;
	localparam int STALL_CYC  = 200;

	logic clk = 1'b0;
	logic arst_n;

	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [M_TUSER_W-1:0]  m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int errors;
	int pending;

	// idling control shared by the sender and the receiver
	logic idle_en     = 1'b1;
	logic stall_phase = 1'b0;
	logic stall_done  = 1'b0;
	int   stall_left  = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	lif_neuron_soma_update_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	lifsoma_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.errors   (errors),
		.pending  (pending)
	);

	// Receiver: while idling is enabled, drop m_tready about 8 percent of the time.
	// Once per run, when the stimulus opens the pressure phase, hold m_tready
	// low so the block fills up and stalls its request side.
	always @(posedge clk) begin
		if (stall_phase && !stall_done) begin
			stall_done <= 1'b1;
			stall_left <= STALL_CYC;
			m_tready   <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (idle_en) begin
			m_tready <= ($urandom_range(99) >= 8);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Offer one request and hold it until the block takes it. A random gap
	// may come first; s_tvalid stays high between back-to-back requests.
	task automatic send_req(input logic [SYN_W-1:0] syn, input logic [NOISE_W-1:0] noise);
		int gap;
		if (idle_en && $urandom_range(99) < 3) begin
			gap = $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W - SYN_W - NOISE_W){1'b0}}, noise, syn};
		do
			@(posedge clk);
		while (!(s_tvalid && s_tready));
	endtask

	// Write one register; cfg_valid is left high for the next write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
	endtask

	// Drop the request side, wait until every result is back, then let the
	// pipeline settle.
	task automatic drain;
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Reload the whole bank; call only after drain. Upper data bits of the
	// narrow registers carry junk that the block must ignore.
	task automatic load_bank(input logic [LEAK_W-1:0] leak, input logic [BIAS_W-1:0] bias,
			input logic [THR_W-1:0] thr, input logic [THR_W-1:0] rev,
			input logic [THR_W-1:0] frst, input logic [THR_W-1:0] rrst,
			input logic [RKIND_W-1:0] kind);
		write_reg(REG_LEAK, {8'($urandom), leak});
		write_reg(REG_BIAS, {8'($urandom), bias});
		write_reg(REG_FIRE_THR, thr);
		write_reg(REG_REV_LIMIT, rev);
		write_reg(REG_FIRE_RESET, frst);
		write_reg(REG_REV_RESET, rrst);
		write_reg(REG_RESET_KIND, {22'($urandom), kind});
		if ($urandom_range(1) == 1)
			write_reg(REG_SPARE, 24'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Signed value in [lo, hi] most of the time, else an extreme or any value.
	function automatic logic [THR_W-1:0] pick24(input int lo, input int hi);
		int v;
		case ($urandom_range(9))
			0:       return SYN_MAX;
			1:       return SYN_MIN;
			2:       return 24'($urandom);
			default: begin
				v = int'($urandom_range(0, hi - lo)) + lo;
				return v[THR_W-1:0];
			end
		endcase
	endfunction

	function automatic logic [LEAK_W-1:0] pick16(input int lo, input int hi);
		int v;
		case ($urandom_range(9))
			0:       return L16_MAX;
			1:       return L16_MIN;
			2:       return 16'($urandom);
			default: begin
				v = int'($urandom_range(0, hi - lo)) + lo;
				return v[LEAK_W-1:0];
			end
		endcase
	endfunction

	// Mostly steps around the thresholds, with extremes and full-range noise.
	function automatic logic [SYN_W-1:0] pick_syn();
		int v;
		case ($urandom_range(19))
			0:       return SYN_MAX;
			1:       return SYN_MIN;
			2, 3:    return 24'($urandom);
			default: begin
				v = int'($urandom_range(0, 6000)) - 3000;
				return v[SYN_W-1:0];
			end
		endcase
	endfunction

	function automatic logic [NOISE_W-1:0] pick_noise();
		if ($urandom_range(7) == 0)
			return 4'($urandom_range(15));
		return 4'($urandom_range(9));
	endfunction

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Defaults after reset: threshold 1, reverse limit most negative, hard.
		send_req(24'd0, 4'd0);          // stays idle
		send_req(24'd0, 4'd1);          // noise alone reaches the threshold
		send_req(SYN_MAX, 4'd9);        // largest input fires
		send_req(SYN_MIN, 4'd0);        // most negative input hits the reverse limit
		send_req(24'd0, 4'd15);         // offset above nine
		send_req(24'hFFFFFF, 4'd0);     // small negative potential, idle
		send_req(24'd0, 4'd10);         // offset ten lifts it over
		drain();

		// Leak pushing away from zero, biggest bias, soft reset at the extremes.
		load_bank(L16_MIN, L16_MAX, SYN_MAX, SYN_MIN, 24'd0, 24'd0, RK_SOFT);
		send_req(SYN_MAX, 4'd0);        // saturates high and fires
		send_req(SYN_MAX, 4'd15);       // noisy value above the potential range
		send_req(SYN_MIN, 4'd0);
		send_req(SYN_MIN, 4'd0);        // reverse, soft add saturates low
		send_req(SYN_MIN, 4'd9);
		drain();

		// Saturate reset with everything firing.
		load_bank(16'd0, L16_MIN, SYN_MIN, SYN_MAX, SYN_MAX, SYN_MIN, RK_SAT);
		send_req(24'd0, 4'd0);
		send_req(SYN_MAX, 4'd3);
		send_req(SYN_MIN, 4'd0);
		drain();

		// Unused reset code: events reported, potential kept.
		load_bank(L16_MAX, 16'd0, SYN_MAX, SYN_MAX, SYN_MAX, SYN_MIN, RK_UNUSED);
		send_req(24'd70000, 4'd0);      // reverse, potential not reset
		send_req(SYN_MAX, 4'd9);        // reverse again, potential ends positive
		send_req(24'd0, 4'd0);
		drain();

		// Hard reset to the extreme reset values.
		load_bank(16'd5, 16'd0, 24'd100, -24'sd100, SYN_MAX, SYN_MIN, RK_HARD);
		send_req(24'd200, 4'd0);        // fire, potential to the top
		send_req(24'd0, 4'd0);          // leak, still fires
		send_req(-24'sd1000, 4'd0);     // small step down, potential back to the top
		send_req(24'd0, 4'd5);
		drain();

		// Random phases, a fresh bank each time. Phase 3 runs with no idling;
		// phase 5 opens with the long receiver hold-off.
		for (int ph = 0; ph < PHASES; ph++) begin
			load_bank(pick16(0, 300), pick16(-200, 200), pick24(1, 4000),
				pick24(-4000, 0), pick24(-2000, 2000), pick24(-2000, 2000),
				2'($urandom_range(3)));
			idle_en <= (ph != 3);
			if (ph == 5)
				stall_phase <= 1'b1;
			@(posedge clk);
			for (int n = 0; n < PHASE_REQS; n++)
				send_req(pick_syn(), pick_noise());
			drain();
		end

		idle_en <= 1'b1;
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2ms;
		$display("tb: errors");
		$finish;
	end

endmodule
